>>> design/sv39ptw_pkg.sv
// ----------------------------------------------------------------------------
// sv39ptw_pkg
// Shared types and constants of the Sv39 page-table walker.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

   localparam int DEFAULT_TABLE_PAGES   = 64;
   localparam int DEFAULT_VA_LIMIT_BITS = 38;

   localparam int VA_W    = 39;
   localparam int IDX_W   = 15;
   localparam int WORD_W  = 64;
   localparam int PPN_W   = 44;
   localparam int PA_W    = 56;
   localparam int STAT_W  = 3;
   localparam int VPN_W   = 27;
   localparam int SLOT_W  = 9;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 64;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_XLATE = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [2:0] STATUS_OK           = 3'd0;
   localparam logic [2:0] STATUS_TOO_LARGE    = 3'd1;
   localparam logic [2:0] STATUS_MISSING      = 3'd2;
   localparam logic [2:0] STATUS_LEAF_INVALID = 3'd3;
   localparam logic [2:0] STATUS_NOT_USER     = 3'd4;
   localparam logic [2:0] STATUS_OUTSIDE      = 3'd5;

   localparam int PTE_V_BIT = 0;
   localparam int PTE_U_BIT = 4;

   typedef struct packed {
      logic [1:0]        op;
      logic              too_large;
      logic              idx_outside;
      logic [VPN_W-1:0]  vpn;
      logic [IDX_W-1:0]  idx;
      logic [WORD_W-1:0] data;
   } job_type;

endpackage

>>> design/sv39ptw_front.sv
// ----------------------------------------------------------------------------
// sv39ptw_front
// Accepts request beats, checks address ranges and queues the jobs.
// ----------------------------------------------------------------------------
module sv39ptw_front #(
   parameter int TABLE_PAGES   = sv39ptw_pkg::DEFAULT_TABLE_PAGES,
   parameter int VA_LIMIT_BITS = sv39ptw_pkg::DEFAULT_VA_LIMIT_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [119:0]         req_tdata,  // virt_addr, entry_index, entry_data
   input  logic [1:0]           req_tuser,  // op
   input  logic                 clear_busy,
   output logic                 q_valid,
   output sv39ptw_pkg::job_type q_job,
   input  logic                 q_pop
);
   import sv39ptw_pkg::*;

   localparam int DEPTH = TABLE_PAGES * 512;

   logic [VA_W-1:0]   req_va;
   logic [IDX_W-1:0]  req_idx;
   logic [WORD_W-1:0] req_data;
   logic              push;
   job_type           new_job;

   job_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign req_va   = req_tdata[38:0];
   assign req_idx  = req_tdata[53:39];
   assign req_data = req_tdata[117:54];

   always_comb begin
      new_job.op          = req_tuser;
      new_job.too_large   = (req_va >> VA_LIMIT_BITS) != '0;
      new_job.idx_outside = ({17'd0, req_idx} >= 32'(DEPTH));
      new_job.vpn         = req_va[38:12];
      new_job.idx         = req_idx;
      new_job.data        = req_data;
   end

   assign req_tready = (count_ff != 2'd2) && !clear_busy;
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != 2'd0);
   assign q_job      = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> design/sv39ptw_back.sv
// ----------------------------------------------------------------------------
// sv39ptw_back
// Owns the page-table store and walks the three levels of a translation.
// ----------------------------------------------------------------------------
module sv39ptw_back #(
   parameter int TABLE_PAGES = sv39ptw_pkg::DEFAULT_TABLE_PAGES
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [sv39ptw_pkg::PPN_W-1:0]  root_page,
   input  logic [sv39ptw_pkg::PPN_W-1:0]  base_page,
   input  logic                           q_valid,
   input  sv39ptw_pkg::job_type           q_job,
   output logic                           q_pop,
   output logic                           clear_busy,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [127:0]                   rsp_tdata   // status, phys_addr, read_word
);
   import sv39ptw_pkg::*;

   localparam int DEPTH  = TABLE_PAGES * 512;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_READ  = 6'b000100,
      S_L2    = 6'b001000,
      S_L1    = 6'b010000,
      S_L0    = 6'b100000
   } back_state_type;

   logic [WORD_W-1:0] store_mem [DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   back_state_type    state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   job_type           job_ff, job_in;
   logic [ADDR_W-1:0] leaf_ff, leaf_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [PA_W-1:0]   pa_ff, pa_in;
   logic [WORD_W-1:0] rd_ff, rd_in;

   logic              rsp_free;
   logic              emit;
   logic [STAT_W-1:0] emit_status;
   logic [PA_W-1:0]   emit_pa;
   logic [WORD_W-1:0] emit_rd;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata;

   logic [PPN_W-1:0]  loc_ppn, loc_off;
   logic [SLOT_W-1:0] loc_slot;
   logic              loc_ok;
   logic [ADDR_W-1:0] loc_word;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign clear_busy = (state_ff == S_CLEAR);

   always_comb begin
      loc_ppn = (state_ff == S_IDLE) ? root_page : rdata_ff[53:10];
      if (state_ff == S_IDLE) begin
         loc_slot = q_job.vpn[26:18];
      end else if (state_ff == S_L2) begin
         loc_slot = job_ff.vpn[17:9];
      end else begin
         loc_slot = job_ff.vpn[8:0];
      end
      loc_off  = loc_ppn - base_page;
      loc_ok   = (loc_ppn >= base_page) && (loc_off < PPN_W'(TABLE_PAGES));
      loc_word = ADDR_W'({loc_off, loc_slot});
   end

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      job_in      = job_ff;
      leaf_in     = leaf_ff;
      q_pop       = 1'b0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_waddr   = loc_word;
      mem_raddr   = loc_word;
      mem_wdata   = '0;
      emit        = 1'b0;
      emit_status = STATUS_OK;
      emit_pa     = '0;
      emit_rd     = '0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid && rsp_free) begin
               q_pop  = 1'b1;
               job_in = q_job;
               unique case (q_job.op)
                  OP_WRITE: begin
                     emit = 1'b1;
                     if (q_job.idx_outside) begin
                        emit_status = STATUS_OUTSIDE;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = ADDR_W'(q_job.idx);
                        mem_wdata = q_job.data;
                     end
                  end
                  OP_READ: begin
                     if (q_job.idx_outside) begin
                        emit        = 1'b1;
                        emit_status = STATUS_OUTSIDE;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = ADDR_W'(q_job.idx);
                        state_in  = S_READ;
                     end
                  end
                  default: begin
                     if (q_job.too_large) begin
                        emit        = 1'b1;
                        emit_status = STATUS_TOO_LARGE;
                     end else if (!loc_ok) begin
                        emit        = 1'b1;
                        emit_status = STATUS_OUTSIDE;
                     end else begin
                        mem_re   = 1'b1;
                        state_in = S_L2;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            if (rsp_free) begin
               emit     = 1'b1;
               emit_rd  = rdata_ff;
               state_in = S_IDLE;
            end
         end
         S_L2, S_L1: begin
            if (rsp_free) begin
               if (!rdata_ff[PTE_V_BIT]) begin
                  emit        = 1'b1;
                  emit_status = STATUS_MISSING;
                  state_in    = S_IDLE;
               end else if (!loc_ok) begin
                  emit        = 1'b1;
                  emit_status = STATUS_OUTSIDE;
                  state_in    = S_IDLE;
               end else begin
                  mem_re   = 1'b1;
                  leaf_in  = loc_word;
                  state_in = (state_ff == S_L2) ? S_L1 : S_L0;
               end
            end
         end
         S_L0: begin
            if (rsp_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
               if (job_ff.op == OP_CLEAR) begin
                  mem_we    = 1'b1;
                  mem_waddr = leaf_ff;
                  mem_wdata = rdata_ff & ~(WORD_W'(1) << PTE_U_BIT);
               end else if (!rdata_ff[PTE_V_BIT]) begin
                  emit_status = STATUS_LEAF_INVALID;
               end else if (!rdata_ff[PTE_U_BIT]) begin
                  emit_status = STATUS_NOT_USER;
               end else begin
                  emit_pa = {rdata_ff[53:10], 12'd0};
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      pa_in        = pa_ff;
      rd_in        = rd_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         status_in    = emit_status;
         pa_in        = emit_pa;
         rd_in        = emit_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= store_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      leaf_ff   <= leaf_in;
      status_ff <= status_in;
      pa_ff     <= pa_in;
      rd_ff     <= rd_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rd_ff, pa_ff, status_ff};

`ifndef SYNTHESIS
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !q_pop)
      else $error("job taken during store clearing");

   a_one_port_op: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("store read and write in the same cycle");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> rsp_free)
      else $error("result produced while the output register is held");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && $past(state_ff) == S_CLEAR)
         |-> ($past(clr_cnt_ff) == ADDR_W'(DEPTH - 1)))
      else $error("clearing pass ended early");
`endif

endmodule

>>> design/sv39_page_table_walk.sv
// ----------------------------------------------------------------------------
// sv39_page_table_walk
// Sv39 page-table walker over an on-chip store of page-table pages.
// ----------------------------------------------------------------------------
// Requests arrive as beats on req_*: req_tuser selects write entry, read
// entry, translate or clear user bit. Each request gives exactly one
// response beat on rsp_* carrying a status, a physical address and a read
// word. The root page and the page held in store page 0 are set through the
// csr_* port, at byte addresses 0 and 8; the user is to write them only
// while the block is idle, which the block itself does not enforce. After
// reset all TABLE_PAGES * 512 words of the store are zeroed while req_tready
// stays low; register writes are taken meanwhile. A translate makes three
// dependent registered reads of the single-port store, then gives its
// result; a clear also writes the leaf back. A read makes one registered
// read, a write or a request rejected on its address range none. One
// request is walked at a time; a two-entry queue in front of the walker
// keeps taking beats while it works. When rsp_tready is low the response
// register holds its beat and the walker stops; the queue then fills and req_tready falls.
// ----------------------------------------------------------------------------
module sv39_page_table_walk #(
   parameter int TABLE_PAGES   = sv39ptw_pkg::DEFAULT_TABLE_PAGES,
   parameter int VA_LIMIT_BITS = sv39ptw_pkg::DEFAULT_VA_LIMIT_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [119:0]                   req_tdata,  // virt_addr, entry_index, entry_data
   input  logic [1:0]                     req_tuser,  // op
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [127:0]                   rsp_tdata,  // status, phys_addr, read_word
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sv39ptw_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [sv39ptw_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [sv39ptw_pkg::CSR_DW-1:0] csr_prdata,
   output logic                           csr_pready
);
   import sv39ptw_pkg::*;

   logic [PPN_W-1:0] root_ff, root_in;
   logic [PPN_W-1:0] base_ff, base_in;
   logic             csr_wr;
   logic             q_valid;
   job_type          q_job;
   logic             q_pop;
   logic             clear_busy;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[3] ? CSR_DW'(base_ff) : CSR_DW'(root_ff);

   always_comb begin
      root_in = root_ff;
      base_in = base_ff;
      if (csr_wr) begin
         if (csr_paddr[3]) begin
            base_in = csr_pwdata[PPN_W-1:0];
         end else begin
            root_in = csr_pwdata[PPN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
         base_ff <= '0;
      end else begin
         root_ff <= root_in;
         base_ff <= base_in;
      end
   end

   sv39ptw_front #(
      .TABLE_PAGES   (TABLE_PAGES),
      .VA_LIMIT_BITS (VA_LIMIT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clear_busy (clear_busy),
      .q_valid    (q_valid),
      .q_job      (q_job),
      .q_pop      (q_pop)
   );

   sv39ptw_back #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .root_page  (root_ff),
      .base_page  (base_ff),
      .q_valid    (q_valid),
      .q_job      (q_job),
      .q_pop      (q_pop),
      .clear_busy (clear_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
